// File: rtl/cpld_pkg.sv
// Shared types and constants for the cartridge page layout decoder.
// No dependencies.
`default_nettype none

package cpld_pkg;

    localparam int unsigned DEF_RAM_BYTES = 65536;
    localparam logic [7:0]  DEF_RAM_FILL  = 8'hff;

    localparam int unsigned ADDR_W  = 16;
    localparam int unsigned DATA_W  = 8;
    localparam int unsigned LAYOUT_W = 32;
    localparam int unsigned PADDR_W = 3;

    localparam logic [12:0] SECTION_MASK = 13'h1fff;

    localparam logic [3:0] NIB_RAM_1K  = 4'ha;
    localparam logic [3:0] NIB_RAM_2K  = 4'hb;
    localparam logic [3:0] NIB_RAM_4K  = 4'hc;
    localparam logic [3:0] NIB_ROM_EMPTY = 4'he;

    localparam logic REG_ROM_LAYOUT = 1'b0;
    localparam logic REG_RAM_LAYOUT = 1'b1;

    localparam logic CMD_WRITE = 1'b1;

    typedef enum logic [1:0] {
        TGT_UNMAPPED = 2'd0,
        TGT_ROM      = 2'd1,
        TGT_EMPTY    = 2'd2,
        TGT_RAM      = 2'd3
    } target_t;

endpackage

`default_nettype wire

// File: rtl/cartridge_page_layout_decoder.sv
// Cartridge page layout decoder: layout registers, RAM store and access decode.
// Depends on cpld_pkg.
//
// Usage:
//   Access channel: drive command, address and write_data with start high; the
//   item is taken at a rising edge where start is high and busy is low.
//   One result follows on the next cycle: done is high for exactly one cycle
//   with read_data, target and rom_address. The receiver cannot stall.
//   Results are registered; a new access may be taken every cycle, since the RAM
//   read port returns data one cycle after the address and a write lands
//   before any later read.
//   Configuration: APB writes at byte address 0 (rom_layout) and 4
//   (ram_layout); pready is always high. Reads return the register value.
//   Reset: both layout registers go to 0xFFFFFFFF and the RAM is swept with
//   RAM_FILL_VALUE, one byte per cycle, over all RAM_BYTES locations. busy is high
//   during the sweep and no access is taken; configuration writes still work.
`default_nettype none

module cartridge_page_layout_decoder #(
    parameter int unsigned RAM_BYTES      = cpld_pkg::DEF_RAM_BYTES,
    parameter logic [7:0]  RAM_FILL_VALUE = cpld_pkg::DEF_RAM_FILL
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic                           command,
    input  wire logic [cpld_pkg::ADDR_W-1:0]    address,
    input  wire logic [cpld_pkg::DATA_W-1:0]    write_data,
    output logic                                done,
    output logic [cpld_pkg::DATA_W-1:0]         read_data,
    output logic [1:0]                          target,
    output logic [cpld_pkg::ADDR_W-1:0]         rom_address,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [cpld_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [cpld_pkg::LAYOUT_W-1:0]  pwdata,
    output logic [cpld_pkg::LAYOUT_W-1:0]       prdata,
    output logic                                pready
);
    import cpld_pkg::*;

    localparam int unsigned AW = (RAM_BYTES > 1) ? $clog2(RAM_BYTES) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(RAM_BYTES - 1);
    localparam logic [18:0] WRAP4 = 19'(RAM_BYTES * 4);
    localparam logic [18:0] WRAP2 = 19'(RAM_BYTES * 2);
    localparam logic [18:0] WRAP1 = 19'(RAM_BYTES);

    logic [LAYOUT_W-1:0] rom_layout_reg;
    logic [LAYOUT_W-1:0] ram_layout_reg;

    logic                clearing_reg;
    logic [AW-1:0]       clr_idx_reg;

    logic [DATA_W-1:0]   mem [RAM_BYTES];
    logic [DATA_W-1:0]   mem_q_reg;

    logic                done_reg;
    logic                use_mem_reg;
    logic [DATA_W-1:0]   rd_reg;
    target_t             tgt_reg;
    logic [ADDR_W-1:0]   rom_addr_reg;

    logic                accept;
    logic                cfg_wr;
    logic [2:0]          section;
    logic [4:0]          nib_shift;
    logic [3:0]          ram_nib;
    logic [3:0]          rom_nib;
    logic                is_ram;
    logic [ADDR_W-1:0]   raw_idx;
    logic [18:0]         w0;
    logic [18:0]         w1;
    logic [18:0]         w2;
    logic [AW-1:0]       ram_idx;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [DATA_W-1:0]   mem_wdata;
    logic [DATA_W-1:0]   rd_next;
    target_t             tgt_next;
    logic [ADDR_W-1:0]   rom_addr_next;

    assign busy   = clearing_reg;
    assign accept = start && !clearing_reg;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[2])
            REG_ROM_LAYOUT: prdata = rom_layout_reg;
            REG_RAM_LAYOUT: prdata = ram_layout_reg;
            default:        prdata = '0;
        endcase
    end

    // section 0 sits in the top nibble
    assign section   = address[15:13];
    assign nib_shift = {section ^ 3'd7, 2'b00};
    assign ram_nib   = 4'(ram_layout_reg >> nib_shift);
    assign rom_nib   = 4'(rom_layout_reg >> nib_shift);

    always_comb
    begin
        is_ram  = 1'b1;
        raw_idx = '0;
        case (ram_nib)
            NIB_RAM_1K: raw_idx = {6'd0, address[9:0]};
            NIB_RAM_2K: raw_idx = {5'd0, address[10:0]};
            NIB_RAM_4K: raw_idx = {4'd0, address[11:0]};
            default:
            begin
                is_ram  = !ram_nib[3];
                raw_idx = {ram_nib[2:0], address[12:0] & SECTION_MASK};
            end
        endcase
    end

    // wrap into the store; raw index is below 8 * RAM_BYTES
    always_comb
    begin
        w0 = {3'b000, raw_idx};
        w1 = (w0 >= WRAP4) ? w0 - WRAP4 : w0;
        w2 = (w1 >= WRAP2) ? w1 - WRAP2 : w1;
        w2 = (w2 >= WRAP1) ? w2 - WRAP1 : w2;
        ram_idx = w2[AW-1:0];
    end

    always_comb
    begin
        rd_next       = 8'hff;
        tgt_next      = TGT_UNMAPPED;
        rom_addr_next = '0;
        if (is_ram)
        begin
            rd_next  = write_data;
            tgt_next = TGT_RAM;
        end
        else if (!rom_nib[3])
        begin
            rd_next       = '0;
            tgt_next      = TGT_ROM;
            rom_addr_next = {rom_nib[2:0], address[12:0]};
        end
        else if (rom_nib == NIB_ROM_EMPTY)
        begin
            tgt_next = TGT_EMPTY;
        end
    end

    always_comb
    begin
        if (clearing_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_idx_reg;
            mem_wdata = RAM_FILL_VALUE;
        end
        else
        begin
            mem_we    = accept && is_ram && (command == CMD_WRITE);
            mem_waddr = ram_idx;
            mem_wdata = write_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q_reg <= mem[ram_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_layout_reg <= '1;
            ram_layout_reg <= '1;
            clearing_reg   <= 1'b1;
            clr_idx_reg    <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (paddr[2])
                    REG_ROM_LAYOUT: rom_layout_reg <= pwdata;
                    REG_RAM_LAYOUT: ram_layout_reg <= pwdata;
                    default:        ;
                endcase
            end
            if (clearing_reg)
            begin
                clr_idx_reg <= clr_idx_reg + AW'(1);
                if (clr_idx_reg == LAST_IDX)
                begin
                    clearing_reg <= 1'b0;
                end
            end
            done_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            use_mem_reg  <= is_ram && (command != CMD_WRITE);
            rd_reg       <= rd_next;
            tgt_reg      <= tgt_next;
            rom_addr_reg <= rom_addr_next;
        end
    end

    assign done        = done_reg;
    assign read_data   = use_mem_reg ? mem_q_reg : rd_reg;
    assign target      = tgt_reg;
    assign rom_address = rom_addr_reg;

endmodule

`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for cartridge_page_layout_decoder: layout programming
// over APB, directed and random bus accesses, result checks against a local model.
// Depends on cpld_pkg and the decoder RTL.
`timescale 1ns / 100ps

module tb;
    import cpld_pkg::*;

    localparam logic       CMD_READ = ~CMD_WRITE;
    localparam logic [3:0] NIB_NONE = 4'hf;
    localparam logic [31:0] ALL_NONE = 32'hffff_ffff;

    typedef struct packed {
        logic        cmd;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } access_t;

    typedef struct packed {
        logic [7:0]  rdata;
        target_t     tgt;
        logic [15:0] raddr;
    } decode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        command = CMD_READ;
    logic [15:0] address = '0;
    logic [7:0]  write_data = '0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [LAYOUT_W-1:0] pwdata = '0;
    wire         busy;
    wire         done;
    wire  [7:0]  read_data;
    wire  [1:0]  target;
    wire  [15:0] rom_address;
    wire  [LAYOUT_W-1:0] prdata;
    wire         pready;

    cartridge_page_layout_decoder u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .address(address), .write_data(write_data),
        .done(done), .read_data(read_data), .target(target), .rom_address(rom_address),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    logic [7:0]  ram_image [0:DEF_RAM_BYTES-1];
    logic [31:0] rom_map = ALL_NONE;
    logic [31:0] ram_map = ALL_NONE;
    access_t     access_queue [$];
    decode_t     expected_decodes [$];
    logic [15:0] hot_addrs [$];
    int          gap_left = 0;
    bit          bursty = 1'b1;
    int          errors = 0;
    int          layouts_used = 1;
    int          hits [4] = '{0, 0, 0, 0};

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic decode_t decode_access(access_t acc);
        decode_t     res;
        logic [3:0]  ram_nib;
        logic [3:0]  rom_nib;
        logic [15:0] idx;
        bit          is_ram;
        int          sec;
        sec = acc.addr[15:13];
        ram_nib = ram_map[(7 - sec) * 4 +: 4];
        rom_nib = rom_map[(7 - sec) * 4 +: 4];
        is_ram = 1'b1;
        idx = '0;
        case (ram_nib)
            NIB_RAM_1K: idx = {6'd0, acc.addr[9:0]};
            NIB_RAM_2K: idx = {5'd0, acc.addr[10:0]};
            NIB_RAM_4K: idx = {4'd0, acc.addr[11:0]};
            default:
            begin
                if (!ram_nib[3])
                    idx = {ram_nib[2:0], acc.addr[12:0]};
                else
                    is_ram = 1'b0;
            end
        endcase
        res = '{rdata: 8'hff, tgt: TGT_UNMAPPED, raddr: 16'd0};
        if (is_ram)
        begin
            if (acc.cmd == CMD_WRITE)
                ram_image[idx] = acc.wdata;
            res.rdata = ram_image[idx];
            res.tgt = TGT_RAM;
        end
        else if (!rom_nib[3])
        begin
            res.rdata = 8'h00;
            res.tgt = TGT_ROM;
            res.raddr = {rom_nib[2:0], acc.addr[12:0]};
        end
        else if (rom_nib == NIB_ROM_EMPTY)
            res.tgt = TGT_EMPTY;
        return res;
    endfunction

    // Inputs change on the falling edge.
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (gap_left != 0)
        begin
            start <= 1'b0;
            gap_left = gap_left - 1;
        end
        else if (access_queue.size() != 0)
        begin
            start <= 1'b1;
            command <= access_queue[0].cmd;
            address <= access_queue[0].addr;
            write_data <= access_queue[0].wdata;
        end
        else
            start <= 1'b0;
    end

    // Result check first, then the item taken at this edge.
    always @(posedge clk)
    begin
        decode_t exp_d;
        if (rst_n && done === 1'b1)
        begin
            if (expected_decodes.size() == 0)
            begin
                $error("unexpected result: read_data %0h target %0d", read_data, target);
                errors++;
            end
            else
            begin
                exp_d = expected_decodes.pop_front();
                hits[exp_d.tgt]++;
                if (read_data !== exp_d.rdata)
                begin
                    $error("read_data: expected %0h, got %0h", exp_d.rdata, read_data);
                    errors++;
                end
                if (target !== exp_d.tgt)
                begin
                    $error("target: expected %0d, got %0d", exp_d.tgt, target);
                    errors++;
                end
                if (rom_address !== exp_d.raddr)
                begin
                    $error("rom_address: expected %0h, got %0h", exp_d.raddr, rom_address);
                    errors++;
                end
            end
        end
        if (rst_n && start && busy === 1'b0)
        begin
            expected_decodes.push_back(decode_access(access_queue.pop_front()));
            if (bursty && $urandom_range(0, 3) == 0)
                gap_left = $urandom_range(1, 4);
        end
    end

    task automatic push_access(logic cmd, logic [15:0] addr, logic [7:0] wdata);
        access_queue.push_back('{cmd: cmd, addr: addr, wdata: wdata});
        if (cmd == CMD_WRITE)
        begin
            hot_addrs.push_back(addr);
            if (hot_addrs.size() > 16)
                void'(hot_addrs.pop_front());
        end
    endtask

    task automatic push_random(int n);
        logic [15:0] addr;
        for (int i = 0; i < n; i++)
        begin
            addr = 16'($urandom);
            // half the time revisit recent writes, sometimes in another section
            if (hot_addrs.size() != 0 && $urandom_range(0, 1) == 0)
            begin
                addr = hot_addrs[$urandom_range(0, hot_addrs.size() - 1)];
                if ($urandom_range(0, 2) == 0)
                    addr[15:13] = 3'($urandom);
            end
            push_access($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, addr, 8'($urandom));
        end
    endtask

    function automatic logic [31:0] random_layout(bit for_ram);
        logic [31:0] lay;
        int          pick;
        for (int s = 0; s < 8; s++)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
                lay[s * 4 +: 4] = 4'($urandom_range(0, 7));
            else if (pick < 7)
                lay[s * 4 +: 4] = for_ram ? 4'($urandom_range(NIB_RAM_1K, NIB_RAM_4K))
                                          : NIB_ROM_EMPTY;
            else if (pick < 9)
                lay[s * 4 +: 4] = NIB_NONE;
            else
                lay[s * 4 +: 4] = for_ram ? (4'($urandom_range(0, 3)) == 0 ? 4'h8 :
                                             4'($urandom_range(0, 1)) ? 4'hd : 4'he)
                                          : 4'($urandom_range(8, 13));
        end
        return lay;
    endfunction

    task automatic wait_drained();
        while (access_queue.size() != 0 || expected_decodes.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic apb_write(logic idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_ROM_LAYOUT)
            rom_map = val;
        else
            ram_map = val;
    endtask

    task automatic set_layout(logic [31:0] rom_lay, logic [31:0] ram_lay);
        wait_drained();
        apb_write(REG_ROM_LAYOUT, rom_lay);
        apb_write(REG_RAM_LAYOUT, ram_lay);
        layouts_used++;
    endtask

    initial
    begin
        for (int i = 0; i < DEF_RAM_BYTES; i++)
            ram_image[i] = DEF_RAM_FILL;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // reset layout: everything unmapped
        push_access(CMD_READ,  16'h0000, 8'h00);
        push_access(CMD_WRITE, 16'h3fff, 8'hff);
        push_access(CMD_READ,  16'h9fff, 8'h00);
        push_access(CMD_WRITE, 16'hffff, 8'h55);

        // ROM pages, empty, odd ROM codes, RAM over ROM, mirrored small RAMs
        set_layout(32'h07e8_f5d3, 32'hff9f_a6bc);
        push_access(CMD_READ,  16'h0000, 8'h00);
        push_access(CMD_READ,  16'h3fff, 8'h00);
        push_access(CMD_WRITE, 16'h0000, 8'hff);
        push_access(CMD_READ,  16'h4000, 8'h00);
        push_access(CMD_WRITE, 16'h7fff, 8'h00);
        push_access(CMD_WRITE, 16'h83ff, 8'ha5);
        push_access(CMD_READ,  16'h87ff, 8'h00);
        push_access(CMD_WRITE, 16'hbfff, 8'h5a);
        push_access(CMD_READ,  16'hbfff, 8'h00);
        push_access(CMD_READ,  16'hc3ff, 8'h00);
        push_access(CMD_WRITE, 16'hdfff, 8'h3c);
        push_access(CMD_READ,  16'he7ff, 8'h00);
        push_access(CMD_WRITE, 16'hffff, 8'hc3);
        push_access(CMD_READ,  16'hefff, 8'h00);

        // RAM codes that mean no RAM, RAM pages over hidden ROM
        set_layout(32'hcbae_9ff0, 32'h8de0_1234);
        push_access(CMD_READ,  16'h0000, 8'h00);
        push_access(CMD_READ,  16'h2000, 8'h00);
        push_access(CMD_WRITE, 16'h5fff, 8'h00);
        push_access(CMD_WRITE, 16'h6000, 8'h00);
        push_access(CMD_READ,  16'h8000, 8'h00);
        push_access(CMD_READ,  16'h7fff, 8'h00);

        set_layout(32'h0000_0000, 32'h0000_0000);
        push_random(90);
        set_layout(ALL_NONE, ALL_NONE);
        push_random(50);
        set_layout(32'h0123_4567, ALL_NONE);
        push_random(90);
        set_layout(ALL_NONE, 32'h7654_3210);
        push_random(90);
        set_layout(32'heeee_eeee, 32'habca_bcab);
        push_random(90);
        for (int k = 0; k < 6; k++)
        begin
            bursty = (k % 3 != 2);
            set_layout(random_layout(1'b0), random_layout(1'b1));
            push_random(100);
        end
        bursty = 1'b0;
        set_layout(random_layout(1'b0), random_layout(1'b1));
        push_random(140);

        wait_drained();
        repeat (4) @(posedge clk);
        $display("Ran %0d layouts; results seen: RAM %0d, ROM page %0d, empty %0d, unmapped %0d.",
                 layouts_used, hits[TGT_RAM], hits[TGT_ROM], hits[TGT_EMPTY],
                 hits[TGT_UNMAPPED]);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #(10_000_000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
